### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define HBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define HBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `HBD_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define HBD_ASSERT(lbl, clk, rstn, prop, msg)
`define HBD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### design/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, constants and the CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam logic [7:0]  FLAG_OCTET   = 8'h7E;
  localparam logic [7:0]  ESC_OCTET    = 8'h7D;
  localparam logic [7:0]  ESC_XOR      = 8'h20;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD     = 16'hF0B8;
  localparam logic [15:0] CRC_POLY     = 16'h8408;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam logic [15:0] OVERHEAD_LEN = 16'd4;

  localparam int          MAX_MIN_LENGTH = 8;
  localparam logic [3:0]  MIN_LEN_FLOOR  = 4'd4;
  localparam logic [3:0]  MIN_LEN_CEIL   = 4'(MAX_MIN_LENGTH);
  localparam int          HB_DEPTH       = MAX_MIN_LENGTH;
  localparam int          HB_IDX_W       = $clog2(HB_DEPTH);
  localparam int          BURST_MAX      = 4;
  localparam int          BURST_IDX_W    = $clog2(BURST_MAX);
  localparam int          BURST_CNT_W    = $clog2(BURST_MAX + 1);
  localparam int          QUEUE_DEPTH    = 2;
  localparam int          QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int          QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_INFO = 1'b0,
    KIND_END  = 1'b1
  } rec_kind_e;

  // One request for the back end: 1 to BURST_MAX records from one line byte.
  typedef struct packed {
    rec_kind_e                      kind;
    logic [BURST_CNT_W-1:0]         cnt;
    logic [BURST_MAX-1:0][7:0]      data;
    logic [7:0]                     addr;
    logic [7:0]                     ctrl;
    logic [15:0]                    len;
    logic                           good;
  } hbd_req_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } hbd_qstat_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [3:0] clamp_min(input logic [3:0] v);
    if (v < MIN_LEN_FLOOR) begin
      return MIN_LEN_FLOOR;
    end else if (v > MIN_LEN_CEIL) begin
      return MIN_LEN_CEIL;
    end
    return v;
  endfunction

endpackage

### design/hbd_front.sv
// ----------------------------------------------------------------------------
// hbd_front
// Unstuffs line bytes, tracks frame state and CRC, builds record requests.
// ----------------------------------------------------------------------------
module hbd_front import hbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic [3:0] min_len_i,
  output logic       push_o,
  output hbd_req_t   req_o
);

  logic                 inside_q, inside_d;
  logic                 esc_q, esc_d;
  logic [15:0]          cnt_q, cnt_d;
  logic [7:0]           addr_q, addr_d;
  logic [7:0]           ctrl_q, ctrl_d;
  logic [15:0]          crc_q, crc_d;
  logic [3:0]           fmin_q, fmin_d;
  logic [7:0]           hb_q [HB_DEPTH];
  logic [7:0]           hb_d [HB_DEPTH];

  logic [7:0]           b;
  logic [15:0]          fmin_w;
  logic [HB_IDX_W-1:0]  tail_idx;
  logic [3:0]           burst_n;

  assign fmin_w   = {12'h000, fmin_q};
  assign tail_idx = HB_IDX_W'(fmin_q - 4'd2);
  assign burst_n  = fmin_q - MIN_LEN_FLOOR;

  always_comb begin
    inside_d = inside_q;
    esc_d    = esc_q;
    cnt_d    = cnt_q;
    addr_d   = addr_q;
    ctrl_d   = ctrl_q;
    crc_d    = crc_q;
    fmin_d   = fmin_q;
    hb_d     = hb_q;
    push_o   = 1'b0;
    req_o    = '0;
    req_o.kind = KIND_INFO;
    b        = esc_q ? (rx_byte_i ^ ESC_XOR) : rx_byte_i;

    if (accept_i) begin
      if (rx_byte_i == FLAG_OCTET) begin
        if (inside_q && (cnt_q >= fmin_w)) begin
          push_o     = 1'b1;
          req_o.kind = KIND_END;
          req_o.cnt  = BURST_CNT_W'(1);
          req_o.addr = addr_q;
          req_o.ctrl = ctrl_q;
          req_o.len  = cnt_q - OVERHEAD_LEN;
          req_o.good = (crc_q == CRC_GOOD);
        end
        inside_d = 1'b1;
        esc_d    = 1'b0;
        cnt_d    = '0;
        crc_d    = CRC_INIT;
        fmin_d   = clamp_min(min_len_i);
      end else if (!inside_q) begin
        // idle bytes before the first flag
      end else if (rx_byte_i == ESC_OCTET) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        crc_d = crc_byte(crc_q, b);
        if (cnt_q < fmin_w) begin
          if (cnt_q == 16'd0) addr_d = b;
          if (cnt_q == 16'd1) ctrl_d = b;
          if (cnt_q < 16'(HB_DEPTH)) hb_d[cnt_q[HB_IDX_W-1:0]] = b;
          if (cnt_q == fmin_w - 16'd1) begin
            // min length reached: release held info bytes, keep the last two back
            for (int k = 0; k < BURST_MAX; k++) begin
              req_o.data[k] = hb_q[k + 2];
            end
            req_o.cnt = BURST_CNT_W'(burst_n);
            push_o    = (burst_n != 4'd0);
            hb_d[0]   = hb_q[tail_idx];
            hb_d[1]   = b;
          end
        end else begin
          push_o        = 1'b1;
          req_o.cnt     = BURST_CNT_W'(1);
          req_o.data[0] = hb_q[0];
          hb_d[0]       = hb_q[1];
          hb_d[1]       = b;
        end
        if (cnt_q != COUNT_MAX) cnt_d = cnt_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      esc_q    <= 1'b0;
      cnt_q    <= '0;
      addr_q   <= '0;
      ctrl_q   <= '0;
      crc_q    <= CRC_INIT;
      fmin_q   <= MIN_LEN_FLOOR;
    end else begin
      inside_q <= inside_d;
      esc_q    <= esc_d;
      cnt_q    <= cnt_d;
      addr_q   <= addr_d;
      ctrl_q   <= ctrl_d;
      crc_q    <= crc_d;
      fmin_q   <= fmin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hb_q <= hb_d;
  end

endmodule

### design/hbd_queue.sv
// ----------------------------------------------------------------------------
// hbd_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module hbd_queue import hbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hbd_req_t   push_req_i,
  input  logic       pop_i,
  output hbd_req_t   head_o,
  output hbd_qstat_t stat_o
);

  hbd_req_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wptr_q, wptr_d;
  logic [QUEUE_PTR_W-1:0] rptr_q, rptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign stat_o.full  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign head_o       = mem_q[rptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_req_i;
  end

endmodule

### design/hbd_back.sv
// ----------------------------------------------------------------------------
// hbd_back
// Expands queued requests into records, one per cycle unless the consumer stalls, into an output register.
// ----------------------------------------------------------------------------
module hbd_back import hbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  hbd_req_t   head_i,
  output logic       pop_o,
  output logic       rec_valid_o,
  input  logic       rec_ready_i,
  output logic       record_kind_o,
  output logic [7:0] info_byte_o,
  output logic [7:0] frame_address_o,
  output logic [7:0] frame_control_o,
  output logic [15:0] info_length_o,
  output logic       fcs_good_o,
  output logic       last_of_run_o
);

  logic [BURST_IDX_W-1:0] idx_q, idx_d;
  logic                   ov_q, ov_d;
  logic                   load, last;

  logic        kind_q;
  logic [7:0]  info_q, addr_q, ctrl_q;
  logic [15:0] len_q;
  logic        good_q, lor_q;

  assign load  = head_valid_i && (!ov_q || rec_ready_i);
  assign last  = (BURST_CNT_W'(idx_q) + BURST_CNT_W'(1)) == head_i.cnt;
  assign pop_o = load && last;

  always_comb begin
    idx_d = idx_q;
    ov_d  = ov_q;
    if (load) begin
      ov_d  = 1'b1;
      idx_d = last ? '0 : idx_q + 1'b1;
    end else if (rec_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      info_q <= head_i.data[idx_q];
      addr_q <= head_i.addr;
      ctrl_q <= head_i.ctrl;
      len_q  <= head_i.len;
      good_q <= head_i.good;
      lor_q  <= last;
    end
  end

  assign rec_valid_o     = ov_q;
  assign record_kind_o   = kind_q;
  assign info_byte_o     = info_q;
  assign frame_address_o = addr_q;
  assign frame_control_o = ctrl_q;
  assign info_length_o   = len_q;
  assign fcs_good_o      = good_q;
  assign last_of_run_o   = lor_q;

endmodule

### design/hdlc_byte_unstuff_deframer.sv
// ----------------------------------------------------------------------------
// hdlc_byte_unstuff_deframer
// Async HDLC byte deframer: unstuffing, CRC-16/X.25 check, info streaming.
// ----------------------------------------------------------------------------
// Path: the line byte that causes a record is registered as a queue request, then in the output register.
// Throughput: one line byte per cycle while the request queue is not full; records
// leave at one per cycle unless the consumer stalls, so the burst at minimum length
// (up to 4 records) holds the front once the two-entry request queue is full.
// Reset: asynchronous, active low; idle before first flag, min length 4.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdlc_byte_unstuff_deframer import hbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        rec_valid_o,
  input  logic        rec_ready_i,
  output logic        record_kind_o,
  output logic [7:0]  info_byte_o,
  output logic [7:0]  frame_address_o,
  output logic [7:0]  frame_control_o,
  output logic [15:0] info_length_o,
  output logic        fcs_good_o,
  output logic        last_of_run_o
);

  logic [3:0] min_len_q;
  logic       accept, push, pop;
  hbd_req_t   push_req, head;
  hbd_qstat_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_FLOOR;
    end else if (cfg_we_i) begin
      min_len_q <= cfg_wdata_i;
    end
  end

  assign rx_ready_o = !qstat.full;
  assign accept     = rx_valid_i && rx_ready_o;

  hbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .min_len_i (min_len_q),
    .push_o    (push),
    .req_o     (push_req)
  );

  hbd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (qstat)
  );

  hbd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!qstat.empty),
    .head_i          (head),
    .pop_o           (pop),
    .rec_valid_o     (rec_valid_o),
    .rec_ready_i     (rec_ready_i),
    .record_kind_o   (record_kind_o),
    .info_byte_o     (info_byte_o),
    .frame_address_o (frame_address_o),
    .frame_control_o (frame_control_o),
    .info_length_o   (info_length_o),
    .fcs_good_o      (fcs_good_o),
    .last_of_run_o   (last_of_run_o)
  );

  `HBD_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push && qstat.full, "request lost: queue full")
  `HBD_ASSERT(a_qcount_range, clk_i, rst_ni, qstat.count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `HBD_ASSERT(a_end_is_last, clk_i, rst_ni, (rec_valid_o && record_kind_o) |-> last_of_run_o, "end record not last of run")
  `HBD_ASSERT(a_info_clean, clk_i, rst_ni, (rec_valid_o && !record_kind_o) |-> (info_length_o == 16'd0 && !fcs_good_o), "info record carries end fields")

endmodule
